### rtl/qtg_pkg.sv
// Shared types, constants, microcode and helper functions of the quintic trajectory generator.
package qtg_pkg;

  // Fixed-point format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int W_W       = 48;
  localparam int ACC_W     = 56;
  localparam int D_W       = 31;
  localparam int NUM_W     = W_W + FRAC_BITS;
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = W_W / MUL_CHUNK;
  localparam int PC_W      = 6;
  localparam int SLOT_W    = 5;
  localparam int K_W       = 8;

  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
  localparam logic signed [W_W-1:0] V_MAX = {{(W_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [W_W-1:0] V_MIN = {{(W_W-31){1'b1}}, {31{1'b0}}};

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_SAT     = 2'd2;

  // Special modes
  localparam logic [2:0] MODE_ZERO = 3'd6;
  localparam logic [2:0] MODE_BAD  = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CFG_P0  = 3'd0;
  localparam logic [2:0] CFG_V0  = 3'd1;
  localparam logic [2:0] CFG_A0  = 3'd2;
  localparam logic [2:0] CFG_PF  = 3'd3;
  localparam logic [2:0] CFG_VF  = 3'd4;
  localparam logic [2:0] CFG_AF  = 3'd5;
  localparam logic [2:0] CFG_DUR = 3'd6;

  // Microcode operations
  localparam logic [2:0] OP_MAC  = 3'd0;
  localparam logic [2:0] OP_SAT  = 3'd1;
  localparam logic [2:0] OP_HALF = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_END  = 3'd5;

  // Operand and destination slots
  localparam logic [SLOT_W-1:0] SL_P0 = 5'd0;
  localparam logic [SLOT_W-1:0] SL_V0 = 5'd1;
  localparam logic [SLOT_W-1:0] SL_A0 = 5'd2;
  localparam logic [SLOT_W-1:0] SL_PF = 5'd3;
  localparam logic [SLOT_W-1:0] SL_VF = 5'd4;
  localparam logic [SLOT_W-1:0] SL_AF = 5'd5;
  localparam logic [SLOT_W-1:0] SL_T  = 5'd6;
  localparam logic [SLOT_W-1:0] SL_T2 = 5'd7;
  localparam logic [SLOT_W-1:0] SL_D0 = 5'd8;
  localparam logic [SLOT_W-1:0] SL_D1 = 5'd9;
  localparam logic [SLOT_W-1:0] SL_D2 = 5'd10;
  localparam logic [SLOT_W-1:0] SL_E1 = 5'd11;
  localparam logic [SLOT_W-1:0] SL_E2 = 5'd12;
  localparam logic [SLOT_W-1:0] SL_H  = 5'd13;
  localparam logic [SLOT_W-1:0] SL_N  = 5'd14;
  localparam logic [SLOT_W-1:0] SL_C0 = 5'd15;
  localparam logic [SLOT_W-1:0] SL_C1 = 5'd16;
  localparam logic [SLOT_W-1:0] SL_C2 = 5'd17;
  localparam logic [SLOT_W-1:0] SL_C3 = 5'd18;
  localparam logic [SLOT_W-1:0] SL_C4 = 5'd19;
  localparam logic [SLOT_W-1:0] SL_C5 = 5'd20;

  typedef struct packed {
    logic signed [31:0] sample_time;
    logic [2:0]         mode;
  } qtg_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } qtg_out_t;

  // Result of a multi-cycle arithmetic unit
  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic signed [W_W-1:0] value;
  } qtg_res_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [SLOT_W-1:0]     src_a;
    logic [SLOT_W-1:0]     src_b;
    logic signed [K_W-1:0] k;
    logic                  clr;
    logic [SLOT_W-1:0]     dst;
  } qtg_uop_t;

  function automatic qtg_uop_t qtg_mk(input logic [2:0] op, input logic [SLOT_W-1:0] a,
                                      input logic [SLOT_W-1:0] b, input int k,
                                      input logic clr, input logic [SLOT_W-1:0] dst);
    qtg_uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.k     = K_W'(k);
    u.clr   = clr;
    u.dst   = dst;
    return u;
  endfunction

  // Boundary solve program
  function automatic qtg_uop_t qtg_uop(input logic [PC_W-1:0] pc);
    qtg_uop_t u;
    case (pc)
      6'd0:  u = qtg_mk(OP_MUL,  SL_T,  SL_T,  0,   1'b0, SL_T2);
      6'd1:  u = qtg_mk(OP_MUL,  SL_V0, SL_T,  0,   1'b0, SL_H);
      6'd2:  u = qtg_mk(OP_MAC,  SL_PF, SL_T,  1,   1'b1, SL_H);
      6'd3:  u = qtg_mk(OP_MAC,  SL_P0, SL_T,  -1,  1'b0, SL_H);
      6'd4:  u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_D0);
      6'd5:  u = qtg_mk(OP_MAC,  SL_D0, SL_T,  1,   1'b1, SL_H);
      6'd6:  u = qtg_mk(OP_MAC,  SL_H,  SL_T,  -1,  1'b0, SL_H);
      6'd7:  u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_D0);
      6'd8:  u = qtg_mk(OP_MUL,  SL_A0, SL_T2, 0,   1'b0, SL_H);
      6'd9:  u = qtg_mk(OP_HALF, SL_H,  SL_T,  0,   1'b0, SL_H);
      6'd10: u = qtg_mk(OP_MAC,  SL_D0, SL_T,  1,   1'b1, SL_H);
      6'd11: u = qtg_mk(OP_MAC,  SL_H,  SL_T,  -1,  1'b0, SL_H);
      6'd12: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_D0);
      6'd13: u = qtg_mk(OP_MUL,  SL_A0, SL_T,  0,   1'b0, SL_H);
      6'd14: u = qtg_mk(OP_MAC,  SL_VF, SL_T,  1,   1'b1, SL_H);
      6'd15: u = qtg_mk(OP_MAC,  SL_V0, SL_T,  -1,  1'b0, SL_H);
      6'd16: u = qtg_mk(OP_MAC,  SL_H,  SL_T,  -1,  1'b0, SL_H);
      6'd17: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_D1);
      6'd18: u = qtg_mk(OP_MAC,  SL_AF, SL_T,  1,   1'b1, SL_H);
      6'd19: u = qtg_mk(OP_MAC,  SL_A0, SL_T,  -1,  1'b0, SL_H);
      6'd20: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_D2);
      6'd21: u = qtg_mk(OP_MUL,  SL_D1, SL_T,  0,   1'b0, SL_E1);
      6'd22: u = qtg_mk(OP_MUL,  SL_D2, SL_T2, 0,   1'b0, SL_E2);
      6'd23: u = qtg_mk(OP_HALF, SL_E2, SL_T,  0,   1'b0, SL_H);
      6'd24: u = qtg_mk(OP_MAC,  SL_D0, SL_T,  10,  1'b1, SL_H);
      6'd25: u = qtg_mk(OP_MAC,  SL_E1, SL_T,  -4,  1'b0, SL_H);
      6'd26: u = qtg_mk(OP_MAC,  SL_H,  SL_T,  1,   1'b0, SL_H);
      6'd27: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_N);
      6'd28: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd29: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd30: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_C3);
      6'd31: u = qtg_mk(OP_MAC,  SL_D0, SL_T,  -15, 1'b1, SL_H);
      6'd32: u = qtg_mk(OP_MAC,  SL_E1, SL_T,  7,   1'b0, SL_H);
      6'd33: u = qtg_mk(OP_MAC,  SL_E2, SL_T,  -1,  1'b0, SL_H);
      6'd34: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_N);
      6'd35: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd36: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd37: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd38: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_C4);
      6'd39: u = qtg_mk(OP_MAC,  SL_D0, SL_T,  6,   1'b1, SL_H);
      6'd40: u = qtg_mk(OP_MAC,  SL_E1, SL_T,  -3,  1'b0, SL_H);
      6'd41: u = qtg_mk(OP_MAC,  SL_H,  SL_T,  1,   1'b0, SL_H);
      6'd42: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_N);
      6'd43: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd44: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd45: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd46: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_N);
      6'd47: u = qtg_mk(OP_DIV,  SL_N,  SL_T,  0,   1'b0, SL_C5);
      6'd48: u = qtg_mk(OP_MAC,  SL_P0, SL_T,  1,   1'b1, SL_H);
      6'd49: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_C0);
      6'd50: u = qtg_mk(OP_MAC,  SL_V0, SL_T,  1,   1'b1, SL_H);
      6'd51: u = qtg_mk(OP_SAT,  SL_T,  SL_T,  0,   1'b0, SL_C1);
      6'd52: u = qtg_mk(OP_HALF, SL_A0, SL_T,  0,   1'b0, SL_C2);
      default: u = qtg_mk(OP_END, SL_T, SL_T,  0,   1'b0, SL_H);
    endcase
    return u;
  endfunction

  // Falling factorial i!/(i-k)! for the derivative weights
  function automatic logic [K_W-1:0] qtg_fall(input logic [2:0] i, input logic [2:0] k);
    logic [K_W-1:0] r;
    case ({i, k})
      6'o00, 6'o10, 6'o20, 6'o30, 6'o40, 6'o50: r = 8'd1;
      6'o11: r = 8'd1;
      6'o21: r = 8'd2;
      6'o22: r = 8'd2;
      6'o31: r = 8'd3;
      6'o32: r = 8'd6;
      6'o33: r = 8'd6;
      6'o41: r = 8'd4;
      6'o42: r = 8'd12;
      6'o43: r = 8'd24;
      6'o44: r = 8'd24;
      6'o51: r = 8'd5;
      6'o52: r = 8'd20;
      6'o53: r = 8'd60;
      6'o54: r = 8'd120;
      6'o55: r = 8'd120;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Halve, rounding half away from zero
  function automatic logic signed [W_W-1:0] qtg_half(input logic signed [W_W-1:0] x);
    logic [W_W-1:0] m;
    m = x[W_W-1] ? -x : x;
    m = (m + W_W'(1)) >> 1;
    return x[W_W-1] ? -m : m;
  endfunction

  function automatic logic qtg_ovf(input logic signed [ACC_W-1:0] x);
    return (x > ACC_W'(W_MAX)) || (x < ACC_W'(W_MIN));
  endfunction

  // Clamp a wide sum to the working range
  function automatic logic signed [W_W-1:0] qtg_sat(input logic signed [ACC_W-1:0] x);
    logic signed [W_W-1:0] r;
    if (x > ACC_W'(W_MAX)) begin
      r = W_MAX;
    end else if (x < ACC_W'(W_MIN)) begin
      r = W_MIN;
    end else begin
      r = x[W_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/qtg_mul.sv
// Sequential fixed-point multiplier: one 48x16 partial product per cycle, then round and clamp.
module qtg_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [qtg_pkg::W_W-1:0] a,
  input  logic signed [qtg_pkg::W_W-1:0] b,
  output qtg_pkg::qtg_res_t              res
);
  import qtg_pkg::*;

  localparam int MW    = 2 * W_W;
  localparam int CNT_W = $clog2(MUL_STEPS + 1);
  localparam logic [MW-1:0] RND = MW'(1) << (FRAC_BITS - 1);

  logic [W_W-1:0]           ua_r, ub_r;
  logic                     neg_r;
  logic [MW-1:0]            prod_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     run_r;
  logic                     done_r;
  logic                     ovf_r;
  logic signed [W_W-1:0]    value_r;
  logic [W_W+MUL_CHUNK-1:0] part;
  logic [MW-1:0]            rnd, lim;

  assign part = ua_r * ub_r[W_W-1 -: MUL_CHUNK];
  assign rnd  = (prod_r + RND) >> FRAC_BITS;
  assign lim  = neg_r ? MW'(W_MAX) + MW'(1) : MW'(W_MAX);
  assign res  = qtg_res_t'({done_r, ovf_r, value_r});

  // Control: run for the partial products, then a rounding step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_W'(MUL_STEPS)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Datapath: latch magnitudes, shift-accumulate, round and clamp
  always_ff @(posedge clk) begin
    if (start) begin
      ua_r   <= a[W_W-1] ? -a : a;
      ub_r   <= b[W_W-1] ? -b : b;
      neg_r  <= a[W_W-1] ^ b[W_W-1];
      prod_r <= '0;
    end else if (run_r) begin
      if (cnt_r == CNT_W'(MUL_STEPS)) begin
        if (rnd > lim) begin
          ovf_r   <= 1'b1;
          value_r <= neg_r ? -lim[W_W-1:0] : lim[W_W-1:0];
        end else begin
          ovf_r   <= 1'b0;
          value_r <= neg_r ? -rnd[W_W-1:0] : rnd[W_W-1:0];
        end
      end else begin
        prod_r <= {prod_r[MW-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + MW'(part);
        ub_r   <= ub_r << MUL_CHUNK;
      end
    end
  end

endmodule

### rtl/qtg_div.sv
// Restoring fixed-point divider by the duration: one quotient bit per cycle, then round and clamp.
module qtg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [qtg_pkg::W_W-1:0] a,
  input  logic [qtg_pkg::D_W-1:0]        d,
  output qtg_pkg::qtg_res_t              res
);
  import qtg_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]      num_r;
  logic [D_W-1:0]        rem_r, d_r;
  logic                  neg_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic                  ovf_r;
  logic signed [W_W-1:0] value_r;
  logic [D_W:0]          rem_sh;
  logic                  ge, rnd_up;
  logic [NUM_W:0]        q, lim;
  logic [W_W-1:0]        ua;

  assign ua     = a[W_W-1] ? -a : a;
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, d_r};
  assign rnd_up = {rem_r, 1'b0} >= {1'b0, d_r};
  assign q      = {1'b0, num_r} + (NUM_W+1)'(rnd_up);
  assign lim    = neg_r ? (NUM_W+1)'(W_MAX) + (NUM_W+1)'(1) : (NUM_W+1)'(W_MAX);
  assign res    = qtg_res_t'({done_r, ovf_r, value_r});

  // Control: one bit per cycle, then the rounding step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_W'(NUM_W)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Datapath: numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {ua, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      d_r   <= d;
      neg_r <= a[W_W-1];
    end else if (run_r) begin
      if (cnt_r == CNT_W'(NUM_W)) begin
        if (q > lim) begin
          ovf_r   <= 1'b1;
          value_r <= neg_r ? -lim[W_W-1:0] : lim[W_W-1:0];
        end else begin
          ovf_r   <= 1'b0;
          value_r <= neg_r ? -q[W_W-1:0] : q[W_W-1:0];
        end
      end else begin
        num_r <= {num_r[NUM_W-2:0], ge};
        rem_r <= ge ? D_W'(rem_sh - {1'b0, d_r}) : rem_sh[D_W-1:0];
      end
    end
  end

endmodule

### rtl/quintic_trajectory_generator_unit.sv
// Top level: boundary solve sequencer, Horner evaluation and the shared arithmetic units.
//
// Every configuration write to index 0 to 6 starts a solve of the six quintic coefficients;
// busy stays high for the write cycle and until the solve ends, most of it spent in twelve
// bit-serial divides (issue, 64 quotient bits, rounding, write-back) in the shared divider.
// A sample item of mode 0 to 5 holds busy until its result is ready: each Horner step is one
// pass through the shared 48x16 sequential multiplier plus issue and accumulate. Modes 6 and
// 7 never raise busy. Each result is shown on out_data for one cycle with strobe, for mode 0
// to 5 in the same cycle as busy falls for it; the receiver cannot stall, so a result must be
// taken in that cycle. A write to register index 7 is ignored. The coefficients read as zero
// after reset.
module quintic_trajectory_generator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  qtg_pkg::qtg_in_t   in_data,
  output logic               strobe,
  output qtg_pkg::qtg_out_t  out_data
);
  import qtg_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SOLVE     = 3'd1;
  localparam logic [2:0] S_SWAIT     = 3'd2;
  localparam logic [2:0] S_EV_INIT   = 3'd3;
  localparam logic [2:0] S_EV_MSTART = 3'd4;
  localparam logic [2:0] S_EV_MWAIT  = 3'd5;
  localparam logic [2:0] S_EV_FIN    = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [PC_W-1:0]         pc_r, pc_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [W_W-1:0]   w_r, w_nxt;
  logic [2:0]              i_r, i_nxt;
  logic                    ov_r, ov_nxt;
  logic                    strobe_r, strobe_nxt;
  qtg_out_t                out_r, out_nxt;
  logic signed [31:0]      t_r;
  logic [2:0]              k_r;

  logic signed [31:0]      p0_r, v0_r, a0_r, pf_r, vf_r, af_r;
  logic [D_W-1:0]          dur_r, t_eff;
  logic signed [W_W-1:0]   t2_r, d0_r, d1_r, d2_r, e1_r, e2_r, h_r, n_r;
  logic signed [W_W-1:0]   coef_r [6];

  logic signed [W_W-1:0]   src_v [2**SLOT_W];
  logic signed [W_W-1:0]   op_a, op_b;
  qtg_uop_t                uop;
  logic                    accept, cfg_hit;

  logic                    wr_en;
  logic signed [W_W-1:0]   wr_val;

  logic                    mul_start, div_start;
  logic signed [W_W-1:0]   mul_a, mul_b;
  qtg_res_t                mul_res, div_res;

  logic signed [ACC_W-1:0] mac_base, mac_sum;
  logic signed [K_W-1:0]   mac_k;
  logic signed [W_W-1:0]   mac_a;
  logic signed [ACC_W-1:0] mac_prod;

  assign cfg_hit  = cfg_we && (cfg_index <= CFG_DUR);
  assign busy     = (state_r != S_IDLE) || cfg_we;
  assign accept   = start && !busy;
  assign strobe   = strobe_r;
  assign out_data = out_r;
  assign t_eff    = (dur_r == '0) ? D_W'(1) : dur_r;
  assign uop      = qtg_uop(pc_r);

  // Shared multiply-accumulate with a small constant weight
  assign mac_prod = mac_k * mac_a;
  assign mac_sum  = mac_base + mac_prod;

  // Operand slots
  always_comb begin
    for (int j = 0; j < 2**SLOT_W; j++) begin
      src_v[j] = '0;
    end
    src_v[SL_P0] = W_W'(p0_r);
    src_v[SL_V0] = W_W'(v0_r);
    src_v[SL_A0] = W_W'(a0_r);
    src_v[SL_PF] = W_W'(pf_r);
    src_v[SL_VF] = W_W'(vf_r);
    src_v[SL_AF] = W_W'(af_r);
    src_v[SL_T]  = W_W'(t_eff);
    src_v[SL_T2] = t2_r;
    src_v[SL_D0] = d0_r;
    src_v[SL_D1] = d1_r;
    src_v[SL_D2] = d2_r;
    src_v[SL_E1] = e1_r;
    src_v[SL_E2] = e2_r;
    src_v[SL_H]  = h_r;
    src_v[SL_N]  = n_r;
  end

  assign op_a = src_v[uop.src_a];
  assign op_b = src_v[uop.src_b];

  qtg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res)
  );

  qtg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (op_a),
    .d     (t_eff),
    .res   (div_res)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    w_nxt      = w_r;
    i_nxt      = i_r;
    ov_nxt     = ov_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    wr_en      = 1'b0;
    wr_val     = qtg_sat(acc_r);
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = op_a;
    mul_b      = op_b;
    mac_base   = uop.clr ? '0 : acc_r;
    mac_k      = uop.k;
    mac_a      = op_a;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_BAD) begin
            strobe_nxt     = 1'b1;
            out_nxt.value  = '0;
            out_nxt.status = STAT_INVALID;
          end else if (in_data.mode == MODE_ZERO) begin
            strobe_nxt     = 1'b1;
            out_nxt.value  = '0;
            out_nxt.status = STAT_OK;
          end else begin
            ov_nxt    = 1'b0;
            state_nxt = S_EV_INIT;
          end
        end
      end
      S_SOLVE: begin
        unique case (uop.op)
          OP_MAC: begin
            acc_nxt = mac_sum;
            pc_nxt  = pc_r + PC_W'(1);
          end
          OP_SAT: begin
            wr_en  = 1'b1;
            pc_nxt = pc_r + PC_W'(1);
          end
          OP_HALF: begin
            wr_en  = 1'b1;
            wr_val = qtg_half(op_a);
            pc_nxt = pc_r + PC_W'(1);
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = S_SWAIT;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_nxt = S_SWAIT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SWAIT: begin
        if (mul_res.done || div_res.done) begin
          wr_en     = 1'b1;
          wr_val    = mul_res.done ? mul_res.value : div_res.value;
          pc_nxt    = pc_r + PC_W'(1);
          state_nxt = S_SOLVE;
        end
      end
      S_EV_INIT: begin
        mac_base  = '0;
        mac_k     = signed'(qtg_fall(3'd5, k_r));
        mac_a     = coef_r[5];
        w_nxt     = qtg_sat(mac_sum);
        ov_nxt    = ov_r | qtg_ovf(mac_sum);
        i_nxt     = 3'd4;
        state_nxt = (k_r == 3'd5) ? S_EV_FIN : S_EV_MSTART;
      end
      S_EV_MSTART: begin
        mul_start = 1'b1;
        mul_a     = w_r;
        mul_b     = W_W'(t_r);
        state_nxt = S_EV_MWAIT;
      end
      S_EV_MWAIT: begin
        mac_base = ACC_W'(mul_res.value);
        mac_k    = signed'(qtg_fall(i_r, k_r));
        mac_a    = coef_r[i_r];
        if (mul_res.done) begin
          w_nxt  = qtg_sat(mac_sum);
          ov_nxt = ov_r | mul_res.ovf | qtg_ovf(mac_sum);
          if (i_r == k_r) begin
            state_nxt = S_EV_FIN;
          end else begin
            i_nxt     = i_r - 3'd1;
            state_nxt = S_EV_MSTART;
          end
        end
      end
      S_EV_FIN: begin
        strobe_nxt = 1'b1;
        if (w_r > V_MAX) begin
          out_nxt.value  = 32'sh7fffffff;
          out_nxt.status = STAT_SAT;
        end else if (w_r < V_MIN) begin
          out_nxt.value  = 32'sh80000000;
          out_nxt.status = STAT_SAT;
        end else begin
          out_nxt.value  = w_r[31:0];
          out_nxt.status = ov_r ? STAT_SAT : STAT_OK;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A configuration write to index 0 to 6 restarts the solve
    if (cfg_hit) begin
      state_nxt = S_SOLVE;
      pc_nxt    = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
    i_r   <= i_nxt;
    ov_r  <= ov_nxt;
    out_r <= out_nxt;
    if (accept) begin
      t_r <= in_data.sample_time;
      k_r <= in_data.mode;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r  <= '0;
      v0_r  <= '0;
      a0_r  <= '0;
      pf_r  <= '0;
      vf_r  <= '0;
      af_r  <= '0;
      dur_r <= D_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_P0:  p0_r  <= cfg_data;
        CFG_V0:  v0_r  <= cfg_data;
        CFG_A0:  a0_r  <= cfg_data;
        CFG_PF:  pf_r  <= cfg_data;
        CFG_VF:  vf_r  <= cfg_data;
        CFG_AF:  af_r  <= cfg_data;
        CFG_DUR: dur_r <= cfg_data[D_W-1:0];
        default: ;
      endcase
    end
  end

  // Solve temporaries and coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 6; j++) begin
        coef_r[j] <= '0;
      end
    end else if (wr_en) begin
      case (uop.dst)
        SL_T2: t2_r      <= wr_val;
        SL_D0: d0_r      <= wr_val;
        SL_D1: d1_r      <= wr_val;
        SL_D2: d2_r      <= wr_val;
        SL_E1: e1_r      <= wr_val;
        SL_E2: e2_r      <= wr_val;
        SL_H:  h_r       <= wr_val;
        SL_N:  n_r       <= wr_val;
        SL_C0: coef_r[0] <= wr_val;
        SL_C1: coef_r[1] <= wr_val;
        SL_C2: coef_r[2] <= wr_val;
        SL_C3: coef_r[3] <= wr_val;
        SL_C4: coef_r[4] <= wr_val;
        SL_C5: coef_r[5] <= wr_val;
        default: ;
      endcase
    end
  end

endmodule

### rtl/qtg_checker.sv
// Port-level checks of the trajectory generator, bound to the top level.
module qtg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_we,
  input logic [2:0]        cfg_index,
  input logic [31:0]       cfg_data,
  input logic              start,
  input logic              busy,
  input qtg_pkg::qtg_in_t  in_data,
  input logic              strobe,
  input qtg_pkg::qtg_out_t out_data
);
  import qtg_pkg::*;

  // An invalid order answers at once with zero and the error status
  a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode == MODE_BAD
    |=> strobe && out_data.status == STAT_INVALID && out_data.value == 0)
    else $error("invalid order item not answered with error status");

  // Mode six answers at once with zero
  a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode == MODE_ZERO
    |=> strobe && out_data.status == STAT_OK && out_data.value == 0)
    else $error("mode six item not answered with zero");

  // A derivative item holds busy and gives no early result
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode < MODE_ZERO |=> busy && !strobe)
    else $error("derivative item did not hold busy");

  // Status code three never shows
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    strobe |-> out_data.status != 2'd3)
    else $error("undefined status code");

  // No result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !strobe)
    else $error("result strobe after reset");

endmodule

bind quintic_trajectory_generator_unit qtg_checker u_qtg_checker (.*);
